### rtl/segint_pkg.sv
package segint_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int NUM_TESTS  = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;

    typedef enum logic [1:0] {
        ORI_COL = 2'd0,
        ORI_CW  = 2'd1,
        ORI_CCW = 2'd2
    } orient_t;

    // differences for orient(P, Q, R)
    typedef struct packed {
        diff_t dqy;
        diff_t drx;
        diff_t dqx;
        diff_t dry;
    } tri_diff_t;

    typedef struct packed {
        prod_t p1;
        prod_t p2;
    } tri_prod_t;

    typedef struct packed {
        tri_diff_t [NUM_TESTS-1:0] tset;
        logic [NUM_TESTS-1:0]      box;
    } s1_t;

    typedef struct packed {
        tri_prod_t [NUM_TESTS-1:0] tset;
        logic [NUM_TESTS-1:0]      box;
    } s2_t;

    typedef struct packed {
        orient_t [NUM_TESTS-1:0] ori;
        logic [NUM_TESTS-1:0]    box;
    } s3_t;

    function automatic diff_t sub_ext(coord_t a, coord_t b);
        diff_t ea;
        diff_t eb;
        ea = {a[COORD_BITS-1], a};
        eb = {b[COORD_BITS-1], b};
        return ea - eb;
    endfunction

    // r between p and q, either order, ends included
    function automatic logic in_range(coord_t p, coord_t q, coord_t r);
        return ((r >= p) && (r <= q)) || ((r >= q) && (r <= p));
    endfunction

    function automatic tri_diff_t mk_tri(coord_t px, coord_t py, coord_t qx,
                                         coord_t qy, coord_t rx, coord_t ry);
        tri_diff_t t;
        t.dqy = sub_ext(qy, py);
        t.drx = sub_ext(rx, qx);
        t.dqx = sub_ext(qx, px);
        t.dry = sub_ext(ry, qy);
        return t;
    endfunction

endpackage

### rtl/segment_intersection_test.sv
// channel | handshake                 | word
// --------+---------------------------+---------------------------------------
// in      | in_valid / in_stall       | ax ay bx by cx cy dx dy (signed)
// out     | out_valid / out_stall     | intersects
//
// One word per cycle sustained while out_stall is low; each of the difference,
// multiply, orientation and decision stages is registered; multiply forms 17x17 products.
// Reset clears only the stage valid bits.
// Each stage holds while it is full and its successor stalls, so bubbles
// close up; in_stall is raised only when all four stages are full and
// out_stall is high.
module segment_intersection_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  segint_pkg::coord_t ax,
    input  segint_pkg::coord_t ay,
    input  segint_pkg::coord_t bx,
    input  segint_pkg::coord_t by,
    input  segint_pkg::coord_t cx,
    input  segint_pkg::coord_t cy,
    input  segint_pkg::coord_t dx,
    input  segint_pkg::coord_t dy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               intersects
);
    import segint_pkg::*;

    logic s1_valid;
    logic s1_stall;
    s1_t  s1_data;
    logic s2_valid;
    logic s2_stall;
    s2_t  s2_data;
    logic s3_valid;
    logic s3_stall;
    s3_t  s3_data;

    segint_diff u_diff (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (in_valid),
        .up_stall (in_stall),
        .ax       (ax),
        .ay       (ay),
        .bx       (bx),
        .by       (by),
        .cx       (cx),
        .cy       (cy),
        .dx       (dx),
        .dy       (dy),
        .dn_valid (s1_valid),
        .dn_stall (s1_stall),
        .dn_data  (s1_data)
    );

    segint_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s1_valid),
        .up_stall (s1_stall),
        .up_data  (s1_data),
        .dn_valid (s2_valid),
        .dn_stall (s2_stall),
        .dn_data  (s2_data)
    );

    segint_orient u_orient (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s2_valid),
        .up_stall (s2_stall),
        .up_data  (s2_data),
        .dn_valid (s3_valid),
        .dn_stall (s3_stall),
        .dn_data  (s3_data)
    );

    segint_decide u_decide (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s3_valid),
        .up_stall (s3_stall),
        .up_data  (s3_data),
        .dn_valid (out_valid),
        .dn_stall (out_stall),
        .hit      (intersects)
    );

endmodule

### rtl/segint_diff.sv
module segint_diff (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_stall,
    input  segint_pkg::coord_t ax,
    input  segint_pkg::coord_t ay,
    input  segint_pkg::coord_t bx,
    input  segint_pkg::coord_t by,
    input  segint_pkg::coord_t cx,
    input  segint_pkg::coord_t cy,
    input  segint_pkg::coord_t dx,
    input  segint_pkg::coord_t dy,
    output logic              dn_valid,
    input  logic              dn_stall,
    output segint_pkg::s1_t   dn_data
);
    import segint_pkg::*;

    logic valid_reg;
    s1_t  data_reg;
    s1_t  data_next;

    always_comb
    begin
        data_next.tset[0] = mk_tri(ax, ay, bx, by, cx, cy);
        data_next.tset[1] = mk_tri(ax, ay, bx, by, dx, dy);
        data_next.tset[2] = mk_tri(cx, cy, dx, dy, ax, ay);
        data_next.tset[3] = mk_tri(cx, cy, dx, dy, bx, by);
        data_next.box[0]  = in_range(ax, bx, cx) && in_range(ay, by, cy);
        data_next.box[1]  = in_range(ax, bx, dx) && in_range(ay, by, dy);
        data_next.box[2]  = in_range(cx, dx, ax) && in_range(cy, dy, ay);
        data_next.box[3]  = in_range(cx, dx, bx) && in_range(cy, dy, by);
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/segint_mul.sv
module segint_mul (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  segint_pkg::s1_t up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output segint_pkg::s2_t dn_data
);
    import segint_pkg::*;

    logic valid_reg;
    s2_t  data_reg;
    s2_t  data_next;

    always_comb
    begin
        for (int i = 0; i < NUM_TESTS; i++)
        begin
            data_next.tset[i].p1 = prod_t'(up_data.tset[i].dqy) * prod_t'(up_data.tset[i].drx);
            data_next.tset[i].p2 = prod_t'(up_data.tset[i].dqx) * prod_t'(up_data.tset[i].dry);
        end
        data_next.box = up_data.box;
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/segint_orient.sv
module segint_orient (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  segint_pkg::s2_t up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output segint_pkg::s3_t dn_data
);
    import segint_pkg::*;

    logic   valid_reg;
    s3_t    data_reg;
    s3_t    data_next;
    cross_t cross_val [NUM_TESTS];

    always_comb
    begin
        for (int i = 0; i < NUM_TESTS; i++)
        begin
            cross_val[i] = cross_t'(up_data.tset[i].p1) - cross_t'(up_data.tset[i].p2);
            if (cross_val[i] == '0)
            begin
                data_next.ori[i] = ORI_COL;
            end
            else if (cross_val[i][CROSS_BITS-1])
            begin
                data_next.ori[i] = ORI_CCW;
            end
            else
            begin
                data_next.ori[i] = ORI_CW;
            end
        end
        data_next.box = up_data.box;
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

endmodule

### rtl/segint_decide.sv
module segint_decide (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  segint_pkg::s3_t up_data,
    output logic            dn_valid,
    input  logic            dn_stall,
    output logic            hit
);
    import segint_pkg::*;

    logic valid_reg;
    logic hit_reg;
    logic hit_next;
    logic general;
    logic touch;

    always_comb
    begin
        general = (up_data.ori[0] != up_data.ori[1]) && (up_data.ori[2] != up_data.ori[3]);
        touch   = 1'b0;
        for (int i = 0; i < NUM_TESTS; i++)
        begin
            touch = touch | ((up_data.ori[i] == ORI_COL) && up_data.box[i]);
        end
        hit_next = general || touch;
    end

    assign up_stall = valid_reg && dn_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!up_stall)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!up_stall && up_valid)
        begin
            hit_reg <= hit_next;
        end
    end

    assign dn_valid = valid_reg;
    assign hit      = hit_reg;

endmodule

### rtl/segint_checker.sv
module segint_checker (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic in_stall,
    input  logic out_valid,
    input  logic out_stall,
    input  logic intersects
);

    // back-pressure only reaches the input from a stalled output word
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled output word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(intersects)))
        else $error("stalled output word changed or vanished");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output word present during reset");

    // an idle input and an empty output held through the sequence leave nothing in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (!in_valid && !out_valid) ##1 (!in_valid && !out_valid)
        ##1 (!in_valid && !out_valid) ##1 (!in_valid && !out_valid)
        |=> !out_valid)
        else $error("output word appeared with no input word");

endmodule

bind segment_intersection_test segint_checker u_segint_checker (.*);

### tb/tb.sv
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import segint_pkg::*;

    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, dx, dy;
    } seg_pair_t;

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
    logic   out_valid;
    logic   out_stall;
    logic   intersects;

    bit expected_hits[$];
    int mismatches;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int corner_vals[7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};

    segment_intersection_test u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ax         (ax),
        .ay         (ay),
        .bx         (bx),
        .by         (by),
        .cx         (cx),
        .cy         (cy),
        .dx         (dx),
        .dy         (dy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .intersects (intersects)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // sign of (Qy-Py)(Rx-Qx) - (Qx-Px)(Ry-Qy); 64-bit is exact at 16-bit coords
    function automatic orient_t orientation(longint px, longint py, longint qx,
                                            longint qy, longint rx, longint ry);
        longint cr;
        cr = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
        if (cr == 0)
            return ORI_COL;
        else if (cr > 0)
            return ORI_CW;
        else
            return ORI_CCW;
    endfunction

    function automatic bit within_box(longint px, longint py, longint qx,
                                      longint qy, longint rx, longint ry);
        return ((rx >= px && rx <= qx) || (rx >= qx && rx <= px)) &&
               ((ry >= py && ry <= qy) || (ry >= qy && ry <= py));
    endfunction

    function automatic bit segments_touch(seg_pair_t p);
        longint ax_l, ay_l, bx_l, by_l, cx_l, cy_l, dx_l, dy_l;
        orient_t o1, o2, o3, o4;
        ax_l = longint'(p.ax);
        ay_l = longint'(p.ay);
        bx_l = longint'(p.bx);
        by_l = longint'(p.by);
        cx_l = longint'(p.cx);
        cy_l = longint'(p.cy);
        dx_l = longint'(p.dx);
        dy_l = longint'(p.dy);
        o1 = orientation(ax_l, ay_l, bx_l, by_l, cx_l, cy_l);
        o2 = orientation(ax_l, ay_l, bx_l, by_l, dx_l, dy_l);
        o3 = orientation(cx_l, cy_l, dx_l, dy_l, ax_l, ay_l);
        o4 = orientation(cx_l, cy_l, dx_l, dy_l, bx_l, by_l);
        if (o1 != o2 && o3 != o4)
            return 1'b1;
        if (o1 == ORI_COL && within_box(ax_l, ay_l, bx_l, by_l, cx_l, cy_l))
            return 1'b1;
        if (o2 == ORI_COL && within_box(ax_l, ay_l, bx_l, by_l, dx_l, dy_l))
            return 1'b1;
        if (o3 == ORI_COL && within_box(cx_l, cy_l, dx_l, dy_l, ax_l, ay_l))
            return 1'b1;
        if (o4 == ORI_COL && within_box(cx_l, cy_l, dx_l, dy_l, bx_l, by_l))
            return 1'b1;
        return 1'b0;
    endfunction

    function automatic seg_pair_t pair_of(int a_x, int a_y, int b_x, int b_y,
                                          int c_x, int c_y, int d_x, int d_y);
        seg_pair_t p;
        p.ax = coord_t'(a_x);
        p.ay = coord_t'(a_y);
        p.bx = coord_t'(b_x);
        p.by = coord_t'(b_y);
        p.cx = coord_t'(c_x);
        p.cy = coord_t'(c_y);
        p.dx = coord_t'(d_x);
        p.dy = coord_t'(d_y);
        return p;
    endfunction

    function automatic int rnd_in(int lo, int hi);
        return int'($urandom_range(hi - lo)) + lo;
    endfunction

    // mostly shaped pairs: collinear, touching, small grid, corners, points
    function automatic seg_pair_t random_pair();
        int kind;
        int ox, oy, sx, sy;
        int k[4];
        seg_pair_t p;
        kind = $urandom_range(9);
        ox = rnd_in(-2000, 2000);
        oy = rnd_in(-2000, 2000);
        sx = rnd_in(-3000, 3000);
        sy = rnd_in(-3000, 3000);
        foreach (k[i])
            k[i] = rnd_in(-10, 10);
        case (kind)
            4, 5:
                p = pair_of(rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6),
                            rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6), rnd_in(-6, 6));
            6:
                p = pair_of(ox + k[0] * sx, oy + k[0] * sy, ox + k[1] * sx, oy + k[1] * sy,
                            ox + k[2] * sx, oy + k[2] * sy, ox + k[3] * sx, oy + k[3] * sy);
            7:
                p = pair_of(ox + k[0] * sx, oy + k[0] * sy, ox + k[1] * sx, oy + k[1] * sy,
                            int'($urandom), int'($urandom),
                            ox + k[2] * sx, oy + k[2] * sy);
            8:
                p = pair_of(corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)],
                            corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)],
                            corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)],
                            corner_vals[$urandom_range(6)], corner_vals[$urandom_range(6)]);
            9:
            begin
                p = pair_of(int'($urandom), int'($urandom), 0, 0,
                            rnd_in(-40, 40), rnd_in(-40, 40), rnd_in(-40, 40),
                            rnd_in(-40, 40));
                if ($urandom_range(1))
                begin
                    p.bx = p.ax;
                    p.by = p.ay;
                end
                else
                begin
                    p.ax = coord_t'(rnd_in(-40, 40));
                    p.ay = coord_t'(rnd_in(-40, 40));
                    p.bx = coord_t'(rnd_in(-40, 40));
                    p.by = coord_t'(rnd_in(-40, 40));
                    p.dx = p.cx;
                    p.dy = p.cy;
                end
            end
            default:
                p = pair_of(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                            int'($urandom), int'($urandom), int'($urandom), int'($urandom));
        endcase
        return p;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_pair(seg_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        ax       <= p.ax;
        ay       <= p.ay;
        bx       <= p.bx;
        by       <= p.by;
        cx       <= p.cx;
        cy       <= p.cy;
        dx       <= p.dx;
        dy       <= p.dy;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        expected_hits.push_back(segments_touch(p));
        @(negedge clk);
    endtask

    task automatic test_extremes();
        send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
        send_pair(pair_of(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767));
        send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_pair(pair_of(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768));
        send_pair(pair_of(-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768));
        send_pair(pair_of(-32768, 0, 32767, 1, -32767, -32768, 32766, 32767));
    endtask

    task automatic test_crossing();
        send_pair(pair_of(0, 0, 10, 10, 0, 10, 10, 0));
        send_pair(pair_of(0, 0, 10, 0, 0, 5, 10, 5));
        send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
        send_pair(pair_of(0, 0, 10, 0, 5, 1, 5, 7));
    endtask

    task automatic test_collinear();
        send_pair(pair_of(0, 0, 10, 0, 5, 0, 20, 0));
        send_pair(pair_of(0, 0, 10, 0, 11, 0, 20, 0));
        send_pair(pair_of(0, 0, 10, 0, 10, 0, 20, 0));
        send_pair(pair_of(-5, -5, 5, 5, 6, 6, 9, 9));
        send_pair(pair_of(0, 0, 10, 10, 2, 2, 3, 3));
    endtask

    task automatic test_degenerate();
        send_pair(pair_of(3, 3, 3, 3, 3, 3, 3, 3));
        send_pair(pair_of(3, 3, 3, 3, 4, 4, 4, 4));
        send_pair(pair_of(0, 0, 10, 10, 5, 5, 5, 5));
        send_pair(pair_of(0, 0, 10, 10, 5, 6, 5, 6));
        send_pair(pair_of(7, 0, 7, 0, 7, -3, 7, 3));
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_pair(random_pair());
    endtask

    // receiver holds off while the sender keeps offering, so the pipe fills
    task automatic test_backpressure();
        int saved_pct;
        saved_pct     = send_idle_pct;
        send_idle_pct = 0;
        hold_cycles   = 40;
        test_random(24);
        send_idle_pct = saved_pct;
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        bit want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word, intersects=%0b", $realtime, intersects);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (intersects !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: intersects expected %0b got %0b",
                                 $realtime, want, intersects);
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        out_stall     = 1'b0;
        ax            = '0;
        ay            = '0;
        bx            = '0;
        by            = '0;
        cx            = '0;
        cy            = '0;
        dx            = '0;
        dy            = '0;
        mismatches    = 0;
        hold_cycles   = 0;
        send_idle_pct = 16;
        recv_idle_pct = 57;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_extremes();
        test_crossing();
        test_collinear();
        test_degenerate();
        test_random(250);
        test_backpressure();

        send_idle_pct = 57;
        recv_idle_pct = 16;
        test_random(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(200);

        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && expected_hits.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
